// File: rtl/tcsv_pkg.sv
package tcsv_pkg;

  localparam int NUM_TAGS   = 11;
  localparam int OUT_CNT_W  = 24;
  localparam int TAG_IDX_W  = 4;

  localparam logic [2:0] IN_PAYLOAD = 3'd6;
  localparam logic [2:0] HDR_TAG_HI = 3'd0;
  localparam logic [2:0] HDR_TAG_LO = 3'd1;
  localparam logic [2:0] HDR_LEN_HI = 3'd2;
  localparam logic [2:0] HDR_LEN_LO = 3'd3;

  localparam logic [15:0] AN_PAYLOAD_LEN = 16'd8;
  localparam logic [32:0] MIN_STREAM_LEN = 33'd6;

  localparam logic [TAG_IDX_W-1:0] TAG_AN_IDX  = 4'd0;
  localparam logic [TAG_IDX_W-1:0] TAG_DO_IDX  = 4'd7;
  localparam logic [TAG_IDX_W-1:0] SUMMARY_IDX = 4'd0;
  localparam logic [TAG_IDX_W-1:0] LAST_IDX    = 4'd11;

  // Status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_LONG        = 4'd2;
  localparam logic [3:0] ST_TRUNCATED   = 4'd3;
  localparam logic [3:0] ST_UNKNOWN_TAG = 4'd4;
  localparam logic [3:0] ST_AN_SIZE     = 4'd5;
  localparam logic [3:0] ST_AN_MISMATCH = 4'd6;
  localparam logic [3:0] ST_TRAILING    = 4'd7;
  localparam logic [3:0] ST_STRUCTURE   = 4'd8;

  // AN, PL, EN, DL, SD, BR, SO, DO, FO, NE, BN
  localparam logic [NUM_TAGS-1:0][15:0] KNOWN_TAGS = {
    16'h424e, 16'h4e45, 16'h464f, 16'h444f, 16'h534f, 16'h4252,
    16'h5344, 16'h444c, 16'h454e, 16'h504c, 16'h414e
  };

  typedef struct packed {
    logic                 hit;
    logic [TAG_IDX_W-1:0] idx;
  } tag_match_t;

  typedef struct packed {
    logic [3:0]                          status;
    logic [15:0]                         canvas_width;
    logic [15:0]                         canvas_height;
    logic [15:0]                         pixel_depth;
    logic [15:0]                         header_trailer;
    logic [OUT_CNT_W-1:0]                record_total;
    logic [31:0]                         stream_length;
    logic [NUM_TAGS-1:0][OUT_CNT_W-1:0]  counts;
  } summary_t;

  function automatic tag_match_t tag_lookup(input logic [15:0] tag);
    tag_match_t m;
    m.hit = 1'b0;
    m.idx = '0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      if (KNOWN_TAGS[i] == tag) begin
        m.hit = 1'b1;
        m.idx = TAG_IDX_W'(i);
      end
    end
    return m;
  endfunction

endpackage

// File: rtl/tcsv_parser.sv
module tcsv_parser #(
  parameter int COUNT_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output tcsv_pkg::summary_t summary
);
  import tcsv_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [2:0]            hdr_pos, hdr_pos_next;
  logic [15:0]           record_tag, record_tag_next;
  logic [15:0]           payload_length, payload_length_next;
  logic [15:0]           payload_received, payload_received_next;
  logic [63:0]           an_capture, an_capture_next;
  logic [63:0]           first_an, first_an_next;
  logic [COUNT_BITS-1:0] tag_counts [NUM_TAGS];
  logic [COUNT_BITS-1:0] tag_counts_next [NUM_TAGS];
  logic [COUNT_BITS-1:0] accepted_records, accepted_records_next;
  logic [32:0]           bytes_seen, bytes_seen_next;
  logic [3:0]            error_code, error_code_next;
  logic                  finish;
  tag_match_t            match;
  logic [3:0]            status;
  logic                  zeroed;

  always_comb begin
    hdr_pos_next          = hdr_pos;
    record_tag_next       = record_tag;
    payload_length_next   = payload_length;
    payload_received_next = payload_received;
    an_capture_next       = an_capture;
    first_an_next         = first_an;
    tag_counts_next       = tag_counts;
    accepted_records_next = accepted_records;
    error_code_next       = error_code;
    finish                = 1'b0;
    bytes_seen_next       = bytes_seen[32] ? bytes_seen : bytes_seen + 33'd1;

    if (error_code == ST_OK) begin
      if (hdr_pos != IN_PAYLOAD) begin
        case (hdr_pos)
          HDR_TAG_HI: record_tag_next     = {data_byte, 8'h00};
          HDR_TAG_LO: record_tag_next     = {record_tag[15:8], data_byte};
          HDR_LEN_HI: payload_length_next = {data_byte, 8'h00};
          HDR_LEN_LO: payload_length_next = {payload_length[15:8], data_byte};
          default: ;
        endcase
        hdr_pos_next = hdr_pos + 3'd1;
        if (hdr_pos_next == IN_PAYLOAD) begin
          payload_received_next = '0;
          an_capture_next       = '0;
          finish                = (payload_length_next == 16'd0);
        end
      end else begin
        an_capture_next       = {an_capture[55:0], data_byte};
        payload_received_next = payload_received + 16'd1;
        finish                = (payload_received_next >= payload_length);
      end
    end

    match = tag_lookup(record_tag_next);

    if (finish) begin
      hdr_pos_next          = '0;
      payload_received_next = '0;
      if (!match.hit) begin
        error_code_next = ST_UNKNOWN_TAG;
      end else begin
        for (int i = 0; i < NUM_TAGS; i++) begin
          if (match.idx == TAG_IDX_W'(i) && tag_counts[i] != COUNT_MAX) begin
            tag_counts_next[i] = tag_counts[i] + COUNT_BITS'(1);
          end
        end
        if (accepted_records != COUNT_MAX) begin
          accepted_records_next = accepted_records + COUNT_BITS'(1);
        end
        if (match.idx == TAG_AN_IDX) begin
          if (payload_length_next != AN_PAYLOAD_LEN) begin
            error_code_next = ST_AN_SIZE;
          end else if (tag_counts[TAG_AN_IDX] == '0) begin
            first_an_next = an_capture_next;
          end else if (first_an != an_capture_next) begin
            error_code_next = ST_AN_MISMATCH;
          end
        end
      end
    end
  end

  // End-of-stream verdict, evaluated on the state this byte leaves behind
  always_comb begin
    zeroed = 1'b0;
    if (bytes_seen_next[32]) begin
      status = ST_LONG;
      zeroed = 1'b1;
    end else if (bytes_seen_next < MIN_STREAM_LEN) begin
      status = ST_SHORT;
      zeroed = 1'b1;
    end else if (error_code_next != ST_OK) begin
      status = error_code_next;
    end else if (hdr_pos_next == IN_PAYLOAD) begin
      status = ST_TRUNCATED;
    end else if (hdr_pos_next != 3'd0) begin
      status = ST_TRAILING;
    end else if (tag_counts_next[TAG_AN_IDX] == '0 ||
                 tag_counts_next[TAG_DO_IDX] != COUNT_BITS'(1)) begin
      status = ST_STRUCTURE;
    end else begin
      status = ST_OK;
    end

    summary.status         = status;
    summary.canvas_width   = zeroed ? 16'd0 : first_an_next[63:48];
    summary.canvas_height  = zeroed ? 16'd0 : first_an_next[47:32];
    summary.pixel_depth    = zeroed ? 16'd0 : first_an_next[31:16];
    summary.header_trailer = zeroed ? 16'd0 : first_an_next[15:0];
    summary.record_total   = zeroed ? '0 : OUT_CNT_W'(accepted_records_next);
    summary.stream_length  = (status == ST_OK) ? bytes_seen_next[31:0] : 32'd0;
    for (int i = 0; i < NUM_TAGS; i++) begin
      summary.counts[i] = zeroed ? '0 : OUT_CNT_W'(tag_counts_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      hdr_pos          <= '0;
      record_tag       <= '0;
      payload_length   <= '0;
      payload_received <= '0;
      an_capture       <= '0;
      first_an         <= '0;
      accepted_records <= '0;
      bytes_seen       <= '0;
      error_code       <= ST_OK;
      for (int i = 0; i < NUM_TAGS; i++) begin
        tag_counts[i] <= '0;
      end
    end else if (accept) begin
      hdr_pos          <= hdr_pos_next;
      record_tag       <= record_tag_next;
      payload_length   <= payload_length_next;
      payload_received <= payload_received_next;
      an_capture       <= an_capture_next;
      first_an         <= first_an_next;
      accepted_records <= accepted_records_next;
      bytes_seen       <= bytes_seen_next;
      error_code       <= error_code_next;
      tag_counts       <= tag_counts_next;
    end
  end

endmodule

// File: rtl/tcsv_emitter.sv
module tcsv_emitter (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  load,
  input  tcsv_pkg::summary_t                    summary,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [tcsv_pkg::TAG_IDX_W-1:0]        tag_index,
  output logic                                  stream_ok,
  output logic [3:0]                            status,
  output logic [15:0]                           canvas_width,
  output logic [15:0]                           canvas_height,
  output logic [15:0]                           pixel_depth,
  output logic [15:0]                           header_trailer,
  output logic [tcsv_pkg::OUT_CNT_W-1:0]        record_total,
  output logic [31:0]                           stream_length,
  output logic [tcsv_pkg::OUT_CNT_W-1:0]        tag_total,
  output logic                                  final_result
);
  import tcsv_pkg::*;

  logic                 busy;
  logic [TAG_IDX_W-1:0] idx;
  summary_t             snap;
  logic                 out_accept;

  assign out_accept = busy && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= SUMMARY_IDX;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= SUMMARY_IDX;
    end else if (out_accept) begin
      if (idx == LAST_IDX) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap <= summary;
    end
  end

  assign result_valid   = busy;
  assign tag_index      = idx;
  assign status         = snap.status;
  assign stream_ok      = (snap.status == ST_OK);
  assign canvas_width   = snap.canvas_width;
  assign canvas_height  = snap.canvas_height;
  assign pixel_depth    = snap.pixel_depth;
  assign header_trailer = snap.header_trailer;
  assign record_total   = snap.record_total;
  assign stream_length  = snap.stream_length;
  assign tag_total      = (idx == SUMMARY_IDX) ? '0 : snap.counts[idx - 4'd1];
  assign final_result   = (idx == LAST_IDX);

`ifndef ASSERT_OFF
  a_load_idle: assert property (@(posedge clk) disable iff (rst) load |-> !busy)
    else $error("summary loaded while a result run is in progress");
  a_idx_range: assert property (@(posedge clk) disable iff (rst) busy |-> idx <= LAST_IDX)
    else $error("result index beyond last count");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
      (out_accept && idx == LAST_IDX) |=> !busy)
    else $error("result run did not end after final word");
  a_len_on_fail: assert property (@(posedge clk) disable iff (rst)
      (busy && snap.status != ST_OK) |-> snap.stream_length == 32'd0)
    else $error("stream length reported on failed stream");
`endif

endmodule

// File: rtl/tagged_chunk_stream_validator.sv
// Tagged chunk stream validator.
// Input channel (data_valid/data_stall): one stream byte per word, with
// last_byte high on the final byte. A word is taken at each clock edge where
// data_valid is high and data_stall low; ordinary bytes go in at one per cycle.
// Each byte is parsed in the same cycle it is taken: the parser state
// registers feed short header/payload logic and the per-tag saturating counters.
// Output channel (result_valid/result_stall): a run of twelve words per stream,
// a summary (tag_index 0) then the eleven per-tag counts, final_result on the
// last. The first word is shown the cycle after the last byte is taken; the run
// advances while result_stall is low and holds while it is high.
// The parser is cleared when the last byte is taken, so the next stream's bytes
// are taken while the run drains; only a further last byte is held off
// (data_stall high) until the run has been delivered, since the result
// register holds one run.
// Reset (rst, synchronous): clear all counts and captured values, drop any run.
module tagged_chunk_stream_validator #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  tag_index,
  output logic        stream_ok,
  output logic [3:0]  status,
  output logic [15:0] canvas_width,
  output logic [15:0] canvas_height,
  output logic [15:0] pixel_depth,
  output logic [15:0] header_trailer,
  output logic [23:0] record_total,
  output logic [31:0] stream_length,
  output logic [23:0] tag_total,
  output logic        final_result
);
  import tcsv_pkg::*;

  logic     accept;
  logic     load;
  summary_t summary;

  // Hold off a last byte while the previous run is still draining
  assign data_stall = result_valid && last_byte;
  assign accept     = data_valid && !data_stall;
  assign load       = accept && last_byte;

  tcsv_parser #(
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .summary   (summary)
  );

  tcsv_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .summary        (summary),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .tag_index      (tag_index),
    .stream_ok      (stream_ok),
    .status         (status),
    .canvas_width   (canvas_width),
    .canvas_height  (canvas_height),
    .pixel_depth    (pixel_depth),
    .header_trailer (header_trailer),
    .record_total   (record_total),
    .stream_length  (stream_length),
    .tag_total      (tag_total),
    .final_result   (final_result)
  );

endmodule

// File: tb/sv/chunk_stream_checker.sv
`timescale 1ns / 1ps

module chunk_stream_checker #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [3:0]  tag_index,
  input  logic        stream_ok,
  input  logic [3:0]  status,
  input  logic [15:0] canvas_width,
  input  logic [15:0] canvas_height,
  input  logic [15:0] pixel_depth,
  input  logic [15:0] header_trailer,
  input  logic [23:0] record_total,
  input  logic [31:0] stream_length,
  input  logic [23:0] tag_total,
  input  logic        final_result,
  output int          fail_count,
  output int          pending_results,
  output int          bytes_taken,
  output int          runs_predicted,
  output int          words_checked,
  output logic [15:0] status_seen
);
  import tcsv_pkg::*;

  localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  typedef struct packed {
    logic [3:0]  tag_idx;
    logic        ok;
    logic [3:0]  code;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] depth;
    logic [15:0] trailer;
    logic [23:0] records;
    logic [31:0] length;
    logic [23:0] count;
    logic        last;
  } result_word_t;

  result_word_t due_results[$];

  // Predicted parser state
  logic [2:0]  hdr_pos;
  logic [15:0] rec_tag;
  logic [15:0] rec_len;
  logic [15:0] rec_got;
  logic [63:0] an_shift;
  logic [63:0] an_first;
  longint      tag_count[NUM_TAGS];
  longint      rec_count;
  logic [32:0] stream_bytes;
  logic [3:0]  err;

  initial begin
    fail_count      = 0;
    pending_results = 0;
    bytes_taken     = 0;
    runs_predicted  = 0;
    words_checked   = 0;
    status_seen     = '0;
  end

  function automatic longint bump(input longint v);
    return (v < COUNT_MAX) ? v + 1 : v;
  endfunction

  task automatic clear_stream();
    hdr_pos      = '0;
    rec_tag      = '0;
    rec_len      = '0;
    rec_got      = '0;
    an_shift     = '0;
    an_first     = '0;
    rec_count    = 0;
    stream_bytes = '0;
    err          = ST_OK;
    for (int i = 0; i < NUM_TAGS; i++) tag_count[i] = 0;
  endtask

  task automatic close_record();
    int   hit;
    logic first_an;
    hit = -1;
    for (int i = 0; i < NUM_TAGS; i++)
      if (KNOWN_TAGS[i] == rec_tag) hit = i;
    hdr_pos = '0;
    rec_got = '0;
    if (hit < 0) begin
      err = ST_UNKNOWN_TAG;
    end else begin
      first_an = (tag_count[TAG_AN_IDX] == 0);
      tag_count[hit] = bump(tag_count[hit]);
      rec_count = bump(rec_count);
      if (hit == TAG_AN_IDX) begin
        if (rec_len != AN_PAYLOAD_LEN) err = ST_AN_SIZE;
        else if (first_an) an_first = an_shift;
        else if (an_first != an_shift) err = ST_AN_MISMATCH;
      end
    end
  endtask

  // Close the stream: one summary word then eleven per-tag words.
  task automatic emit_result_run();
    logic [3:0]   st;
    logic         zeroed;
    logic [63:0]  fields;
    logic [23:0]  recs;
    logic [31:0]  len;
    result_word_t w;
    zeroed = 1'b0;
    if (stream_bytes > 33'hffff_ffff) begin
      st = ST_LONG;
      zeroed = 1'b1;
    end else if (stream_bytes < MIN_STREAM_LEN) begin
      st = ST_SHORT;
      zeroed = 1'b1;
    end else if (err != ST_OK) begin
      st = err;
    end else if (hdr_pos == IN_PAYLOAD) begin
      st = ST_TRUNCATED;
    end else if (hdr_pos != '0) begin
      st = ST_TRAILING;
    end else if (tag_count[TAG_AN_IDX] == 0 || tag_count[TAG_DO_IDX] != 1) begin
      st = ST_STRUCTURE;
    end else begin
      st = ST_OK;
    end
    fields = zeroed ? '0 : an_first;
    recs   = zeroed ? '0 : rec_count[23:0];
    len    = (st == ST_OK) ? stream_bytes[31:0] : '0;
    for (int k = 0; k <= NUM_TAGS; k++) begin
      w.tag_idx = 4'(k);
      w.ok      = (st == ST_OK);
      w.code    = st;
      w.width   = fields[63:48];
      w.height  = fields[47:32];
      w.depth   = fields[31:16];
      w.trailer = fields[15:0];
      w.records = recs;
      w.length  = len;
      w.count   = (k > 0 && !zeroed) ? tag_count[k-1][23:0] : '0;
      w.last    = (k == NUM_TAGS);
      due_results.push_back(w);
    end
    status_seen[st] = 1'b1;
    runs_predicted++;
    clear_stream();
  endtask

  task automatic take_stream_byte(input logic [7:0] b, input logic fin);
    if (stream_bytes < 33'h1_0000_0000) stream_bytes++;
    // Once an error is latched, only the byte count advances.
    if (err == ST_OK) begin
      if (hdr_pos < IN_PAYLOAD) begin
        case (hdr_pos)
          HDR_TAG_HI: rec_tag = {b, 8'h00};
          HDR_TAG_LO: rec_tag = rec_tag | {8'h00, b};
          HDR_LEN_HI: rec_len = {b, 8'h00};
          HDR_LEN_LO: rec_len = rec_len | {8'h00, b};
          default: ;
        endcase
        hdr_pos++;
        if (hdr_pos == IN_PAYLOAD) begin
          rec_got  = '0;
          an_shift = '0;
          if (rec_len == '0) close_record();
        end
      end else begin
        an_shift = {an_shift[55:0], b};
        rec_got++;
        if (rec_got >= rec_len) close_record();
      end
    end
    bytes_taken++;
    if (fin) emit_result_run();
  endtask

  task automatic report(input string what, input longint got, input longint want);
    fail_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_word();
    result_word_t want;
    if (due_results.size() == 0) begin
      report("unexpected result word, tag_index", tag_index, 0);
    end else begin
      want = due_results.pop_front();
      words_checked++;
      if (tag_index !== want.tag_idx) report("tag_index", tag_index, want.tag_idx);
      if (stream_ok !== want.ok) report("stream_ok", stream_ok, want.ok);
      if (status !== want.code) report("status", status, want.code);
      if (canvas_width !== want.width) report("canvas_width", canvas_width, want.width);
      if (canvas_height !== want.height) report("canvas_height", canvas_height, want.height);
      if (pixel_depth !== want.depth) report("pixel_depth", pixel_depth, want.depth);
      if (header_trailer !== want.trailer)
        report("header_trailer", header_trailer, want.trailer);
      if (record_total !== want.records) report("record_total", record_total, want.records);
      if (stream_length !== want.length) report("stream_length", stream_length, want.length);
      if (tag_total !== want.count) report("tag_total", tag_total, want.count);
      if (final_result !== want.last) report("final_result", final_result, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_stream();
      due_results.delete();
    end else begin
      if (result_valid && !result_stall) check_word();
      if (data_valid && !data_stall) take_stream_byte(data_byte, last_byte);
    end
    pending_results <= due_results.size();
  end

endmodule

// File: tb/sv/tb_tagged_chunk_stream_validator.sv
`timescale 1ns / 1ps

module tb_tagged_chunk_stream_validator;
  import tcsv_pkg::*;

  localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int PHASE_BYTES    = 105;
  localparam int DRAIN_CYCLES   = 20;

  // Shapes of stream the generator can build: a clean one, or one carrying a flaw
  typedef enum int {
    SK_CLEAN,
    SK_AN_SIZE,
    SK_AN_MISMATCH,
    SK_UNKNOWN,
    SK_TRUNCATED,
    SK_TRAILING,
    SK_NO_DO,
    SK_TWO_DO,
    SK_NO_AN,
    SK_NOISE
  } stream_kind_e;

  localparam int NUM_FLAWS = 9;

  logic        clk = 1'b0;
  logic        rst;
  logic        data_valid;
  logic        data_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [3:0]  tag_index;
  logic        stream_ok;
  logic [3:0]  status;
  logic [15:0] canvas_width;
  logic [15:0] canvas_height;
  logic [15:0] pixel_depth;
  logic [15:0] header_trailer;
  logic [23:0] record_total;
  logic [31:0] stream_length;
  logic [23:0] tag_total;
  logic        final_result;

  int          fail_count;
  int          pending_results;
  int          bytes_taken;
  int          runs_predicted;
  int          words_checked;
  logic [15:0] status_seen;

  // Idle rates per side, in percent; the stimulus sets them per phase
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // Each increment asks the receiver for one long hold-off
  int hold_requests = 0;

  logic [7:0]  stream_q[$];
  logic [63:0] canvas;
  int          bytes_sent = 0;
  int          flaw_turn  = 0;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  tagged_chunk_stream_validator u_top (.*);

  chunk_stream_checker u_checker (.*);

  // Receiver: stall at random, or hold off for a long stretch on request.
  // The hold-off is counted here so the sender keeps offering words meanwhile.
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stream building: append to stream_q

  function automatic void put_header(input logic [15:0] tag, input logic [15:0] len);
    stream_q.push_back(tag[15:8]);
    stream_q.push_back(tag[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    // the two spare header bytes carry noise
    stream_q.push_back(8'($urandom));
    stream_q.push_back(8'($urandom));
  endfunction

  function automatic void put_record(input logic [15:0] tag, input int len);
    put_header(tag, 16'(len));
    for (int i = 0; i < len; i++) stream_q.push_back(8'($urandom));
  endfunction

  // Payload beyond the eight field bytes is filled with noise
  function automatic void put_an(input logic [63:0] fields, input int len);
    put_header(KNOWN_TAGS[TAG_AN_IDX], 16'(len));
    for (int i = 0; i < len; i++)
      stream_q.push_back((i < 8) ? fields[63 - 8*i -: 8] : 8'($urandom));
  endfunction

  // Known tag other than AN and DO
  function automatic logic [15:0] filler_tag();
    int i;
    i = $urandom_range(1, NUM_TAGS - 2);
    if (i >= TAG_DO_IDX) i++;
    return KNOWN_TAGS[i];
  endfunction

  function automatic void build_stream(input stream_kind_e kind);
    int fillers;
    int do_slot;
    int flaw_slot;
    int bad_len;
    int cut_len;
    stream_q.delete();
    case ($urandom_range(0, 3))
      0: canvas = '0;
      1: canvas = '1;
      default: canvas = {32'($urandom), 32'($urandom)};
    endcase
    if (kind == SK_NOISE) begin
      for (int i = $urandom_range(1, 14); i > 0; i--) stream_q.push_back(8'($urandom));
    end else begin
      if (kind != SK_NO_AN) put_an(canvas, 8);
      fillers   = $urandom_range(0, 1);
      do_slot   = $urandom_range(0, fillers);
      flaw_slot = $urandom_range(0, fillers);
      for (int i = 0; i <= fillers; i++) begin
        if (i == do_slot && kind != SK_NO_DO) begin
          put_record(KNOWN_TAGS[TAG_DO_IDX], $urandom_range(0, 2));
          if (kind == SK_TWO_DO) put_record(KNOWN_TAGS[TAG_DO_IDX], $urandom_range(0, 2));
        end
        if (i == flaw_slot) begin
          case (kind)
            SK_AN_SIZE: begin
              bad_len = $urandom_range(0, 11);
              if (bad_len >= 8) bad_len++;
              put_an({32'($urandom), 32'($urandom)}, bad_len);
            end
            // flip one bit of the captured canvas so the repeat disagrees
            SK_AN_MISMATCH: put_an(canvas ^ (64'd1 << $urandom_range(0, 63)), 8);
            SK_UNKNOWN: put_record(16'($urandom), $urandom_range(0, 2));
            default: ;
          endcase
        end
        if (i < fillers) put_record(filler_tag(), $urandom_range(0, 2));
      end
      if (kind == SK_TRUNCATED) begin
        // full header, payload cut short; the length is any nonzero value
        bad_len = $urandom_range(1, 65535);
        put_header(KNOWN_TAGS[$urandom_range(0, NUM_TAGS - 1)], 16'(bad_len));
        cut_len = $urandom_range(0, (bad_len > 3) ? 3 : bad_len - 1);
        for (int i = 0; i < cut_len; i++) stream_q.push_back(8'($urandom));
      end
      if (kind == SK_TRAILING)
        for (int i = $urandom_range(1, 5); i > 0; i--) stream_q.push_back(8'($urandom));
    end
  endfunction

  // Offer one word; called and left at a falling edge, with valid still high
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte  <= b;
    last_byte  <= fin;
    do @(posedge clk); while (data_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    for (int i = 0; i < stream_q.size(); i++)
      send_byte(stream_q[i], i == stream_q.size() - 1);
  endtask

  // Drop valid and hold the sender until every predicted word has arrived
  task automatic drain_results();
    data_valid <= 1'b0;
    wait (pending_results == 0);
    @(negedge clk);
  endtask

  // Two streams in three rotate through the flaws; the rest are clean half the time
  task automatic send_random_stream();
    stream_kind_e kind;
    if ((runs_predicted % 3) != 2) begin
      kind = stream_kind_e'(1 + flaw_turn % NUM_FLAWS);
      flaw_turn++;
    end else if ($urandom_range(0, 3) < 2) begin
      kind = SK_CLEAN;
    end else begin
      kind = stream_kind_e'($urandom_range(1, NUM_FLAWS));
    end
    build_stream(kind);
    send_stream();
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input logic squeeze);
    int start;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = bytes_sent;
    if (squeeze) begin
      // Park one run in the result register, then ask for a long hold-off and
      // keep offering: the next last byte must be held back at the input.
      build_stream(SK_CLEAN);
      send_stream();
      hold_requests <= hold_requests + 1;
      build_stream(SK_CLEAN);
      send_stream();
      build_stream(SK_TRAILING);
      send_stream();
    end
    while (bytes_sent - start < PHASE_BYTES) send_random_stream();
    drain_results();
  endtask

  initial begin
    rst        = 1'b1;
    data_valid = 1'b0;
    data_byte  = '0;
    last_byte  = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 25;
    rx_idle_pct = 73;

    // Directed: a one-byte stream of all ones, too short
    stream_q.delete();
    stream_q.push_back(8'hff);
    send_stream();
    // Five zero bytes: still short of one header
    stream_q.delete();
    repeat (5) stream_q.push_back(8'h00);
    send_stream();
    // Lone record with an unknown tag and no payload
    stream_q.delete();
    put_header(16'hffff, 16'h0000);
    send_stream();
    // Complete DO record, then a stray partial header
    stream_q.delete();
    put_header(KNOWN_TAGS[TAG_DO_IDX], 16'h0000);
    stream_q.push_back(8'h41);
    stream_q.push_back(8'h4e);
    send_stream();
    drain_results();

    // Random phases: slow receiver, slow sender, then flat out with a squeeze
    run_phase(25, 73, 1'b0);
    run_phase(73, 25, 1'b0);
    run_phase(0, 0, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d stream bytes, %0d result runs, %0d result words checked",
             bytes_taken, runs_predicted, words_checked);
    $display("Status codes reached (bit per code): %b", status_seen);
    if (fail_count == 0 && pending_results == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: tagged_chunk_stream_validator.f
rtl/tcsv_pkg.sv
rtl/tcsv_parser.sv
rtl/tcsv_emitter.sv
rtl/tagged_chunk_stream_validator.sv
tb/sv/chunk_stream_checker.sv
tb/sv/tb_tagged_chunk_stream_validator.sv
